// ----- sv/afip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII frame integer parser package
// Shared character codes, parse phases, defaults and the number state type.
// ----------------------------------------------------------------------------
package afip_pkg;

    // Default sizing handed to the top level parameters.
    localparam int FRAME_CAPACITY_DEF = 32;
    localparam int FIELD_COUNT_DEF    = 8;

    // Number of value ports on the result channel.
    localparam int OUT_VALUES = 8;

    // Frame control characters.
    localparam logic [7:0] CHAR_START = 8'h53;  // 'S'
    localparam logic [7:0] CHAR_END   = 8'h45;  // 'E'
    localparam logic [7:0] CHAR_SEP   = 8'h26;  // '&'
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Number parse phases.
    localparam logic [1:0] PH_SKIP   = 2'd0;  // skipping leading whitespace
    localparam logic [1:0] PH_SIGN   = 2'd1;  // sign taken
    localparam logic [1:0] PH_DIGITS = 2'd2;  // inside the digits
    localparam logic [1:0] PH_DONE   = 2'd3;  // number finished

    // Magnitude cap, one past the largest positive value.
    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    // State of the number being parsed.
    typedef struct packed {
        logic [1:0]  phase;
        logic        negative;
        logic [31:0] accum;
    } num_state_t;

endpackage

// ----- sv/afip_number_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII frame integer parser number unit
// Applies one content character to the number state and forms the saturated
// signed value of the number parsed so far.
// ----------------------------------------------------------------------------
module afip_number_unit import afip_pkg::*; (
    input  num_state_t         cur,
    input  logic [7:0]         char_in,
    output num_state_t         nxt,
    output logic signed [31:0] value
);

    logic        is_digit;
    logic        is_blank;
    logic        is_sign;
    logic [35:0] acc_times_ten;
    logic [35:0] acc_sum;

    // Character classes.
    assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
    assign is_blank = (char_in == CHAR_SPACE) ||
                      ((char_in >= CHAR_TAB) && (char_in <= CHAR_CR));
    assign is_sign  = (char_in == CHAR_PLUS) || (char_in == CHAR_MINUS);

    // Decimal step: accumulator times ten plus the digit, as shifts and adds.
    assign acc_times_ten = {1'b0, cur.accum, 3'b000} + {3'b000, cur.accum, 1'b0};
    assign acc_sum       = acc_times_ten + {32'd0, char_in[3:0]};

    // Next number state.
    always_comb begin
        nxt = cur;
        if (cur.phase != PH_DONE) begin
            if (is_digit) begin
                nxt.accum = (acc_sum > {4'd0, MAG_CAP}) ? MAG_CAP : acc_sum[31:0];
                nxt.phase = PH_DIGITS;
            end else if ((cur.phase == PH_SKIP) && is_blank) begin
                nxt = cur;
            end else if ((cur.phase == PH_SKIP) && is_sign) begin
                nxt.negative = (char_in == CHAR_MINUS);
                nxt.phase    = PH_SIGN;
            end else begin
                nxt.phase = PH_DONE;
            end
        end
    end

    // Saturated signed value; a negative magnitude of 2^31 wraps to the minimum.
    always_comb begin
        if (cur.negative) begin
            value = signed'(32'd0 - cur.accum);
        end else if (cur.accum[31]) begin
            value = signed'(POS_MAX);
        end else begin
            value = signed'(cur.accum);
        end
    end

endmodule

// ----- sv/ascii_frame_integer_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII frame integer parser core
// Parses frames 'S' v0&v1&...'E' of decimal fields and emits one result beat
// per closed frame with the saturated values, frame number and field count.
// ----------------------------------------------------------------------------
// Timing: an accepted closing 'E' beat is loaded into the input register, and
// the result beat formed from it is then loaded into the result register once
// that register is free.
// Throughput: one byte per cycle; the only stall is a closing 'E' meeting a
// result beat that has not been taken, which holds the input register.
// Reset: aresetn is synchronous and active low; it closes any open frame,
// clears the frame counter and empties both registers.
module ascii_frame_integer_parser_core import afip_pkg::*; #(
    parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF,
    parameter int FIELD_COUNT    = FIELD_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               s_buffer_start,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value_0,
    output logic signed [31:0] m_value_1,
    output logic signed [31:0] m_value_2,
    output logic signed [31:0] m_value_3,
    output logic signed [31:0] m_value_4,
    output logic signed [31:0] m_value_5,
    output logic signed [31:0] m_value_6,
    output logic signed [31:0] m_value_7,
    output logic [15:0]        m_frame_number,
    output logic [3:0]         m_fields_found
);

    localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);
    localparam int IDX_W = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIELD_COUNT - 1);
    localparam logic [CNT_W-1:0] CAP      = CNT_W'(FRAME_CAPACITY);

    // Input register.
    logic                     in_valid_reg, in_valid_next;
    logic [7:0]               in_byte_reg;
    logic                     in_start_reg;

    // Frame state.
    logic [CNT_W-1:0]         stored_count_reg, stored_count_next;
    logic [IDX_W-1:0]         field_index_reg, field_index_next;
    logic                     content_ended_reg, content_ended_next;
    logic [15:0]              frame_counter_reg, frame_counter_next;
    num_state_t               num_reg, num_next;
    logic signed [31:0]       field_values_reg [FIELD_COUNT];
    logic signed [31:0]       field_values_next [FIELD_COUNT];

    // Result register.
    logic                     m_valid_reg, m_valid_next;
    logic signed [31:0]       out_values_reg [OUT_VALUES];
    logic signed [31:0]       result_values [OUT_VALUES];
    logic [15:0]              out_frame_reg;
    logic [3:0]               out_found_reg;

    // Helpers.
    num_state_t               num_stepped;
    logic signed [31:0]       cur_value;
    logic [CNT_W-1:0]         stored_eff;
    logic [15:0]              counter_eff;
    logic                     is_close;
    logic                     advance;
    logic                     load_out;

    afip_number_unit u_number (
        .cur     (num_reg),
        .char_in (in_byte_reg),
        .nxt     (num_stepped),
        .value   (cur_value)
    );

    // A buffer start closes the frame and clears the counter before the byte acts.
    assign stored_eff  = in_start_reg ? '0 : stored_count_reg;
    assign counter_eff = in_start_reg ? 16'd0 : frame_counter_reg;
    assign is_close    = (in_byte_reg == CHAR_END) && (stored_eff != '0);

    // The held beat moves on unless it closes a frame and the result is occupied.
    assign advance  = in_valid_reg && (!is_close || !m_valid_reg || m_ready);
    assign load_out = advance && is_close;
    assign s_ready  = !in_valid_reg || advance;

    // Result values with the open field committed at its index.
    for (genvar k = 0; k < OUT_VALUES; k++) begin : g_result
        if (k < FIELD_COUNT) begin : g_live
            assign result_values[k] = (field_index_reg == IDX_W'(k)) ?
                                      cur_value : field_values_reg[k];
        end else begin : g_zero
            assign result_values[k] = '0;
        end
    end

    // Frame state update for the beat in the input register.
    always_comb begin
        stored_count_next  = stored_count_reg;
        field_index_next   = field_index_reg;
        content_ended_next = content_ended_reg;
        frame_counter_next = frame_counter_reg;
        num_next           = num_reg;
        field_values_next  = field_values_reg;
        if (advance) begin
            stored_count_next  = stored_eff;
            frame_counter_next = counter_eff;
            if (in_byte_reg == CHAR_START) begin
                stored_count_next  = CNT_W'(1);
                field_index_next   = '0;
                content_ended_next = 1'b0;
                num_next           = '0;
                for (int k = 0; k < FIELD_COUNT; k++) begin
                    field_values_next[k] = '0;
                end
            end else if (stored_eff == '0) begin
                stored_count_next = '0;
            end else if (in_byte_reg == CHAR_END) begin
                stored_count_next  = '0;
                field_index_next   = '0;
                content_ended_next = 1'b0;
                num_next           = '0;
                frame_counter_next = counter_eff + 16'd1;
            end else if (stored_eff < CAP) begin
                stored_count_next = stored_eff + CNT_W'(1);
                if (!content_ended_reg) begin
                    if (in_byte_reg == CHAR_NUL) begin
                        content_ended_next = 1'b1;
                    end else if (in_byte_reg == CHAR_SEP) begin
                        if (field_index_reg != LAST_IDX) begin
                            for (int k = 0; k < FIELD_COUNT; k++) begin
                                if (field_index_reg == IDX_W'(k)) begin
                                    field_values_next[k] = cur_value;
                                end
                            end
                            field_index_next = field_index_reg + IDX_W'(1);
                            num_next         = '0;
                        end else begin
                            num_next.phase = PH_DONE;
                        end
                    end else begin
                        num_next = num_stepped;
                    end
                end
            end
        end
    end

    // Handshake state for both registers.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            stored_count_reg  <= '0;
            field_index_reg   <= '0;
            content_ended_reg <= 1'b0;
            frame_counter_reg <= 16'd0;
            num_reg           <= '0;
        end else begin
            in_valid_reg      <= in_valid_next;
            m_valid_reg       <= m_valid_next;
            stored_count_reg  <= stored_count_next;
            field_index_reg   <= field_index_next;
            content_ended_reg <= content_ended_next;
            frame_counter_reg <= frame_counter_next;
            num_reg           <= num_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        field_values_reg <= field_values_next;
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_rx_byte;
            in_start_reg <= s_buffer_start;
        end
        if (load_out) begin
            out_values_reg <= result_values;
            out_frame_reg  <= counter_eff;
            out_found_reg  <= 4'(field_index_reg) + 4'd1;
        end
    end

    // Result ports.
    assign m_valid        = m_valid_reg;
    assign m_value_0      = out_values_reg[0];
    assign m_value_1      = out_values_reg[1];
    assign m_value_2      = out_values_reg[2];
    assign m_value_3      = out_values_reg[3];
    assign m_value_4      = out_values_reg[4];
    assign m_value_5      = out_values_reg[5];
    assign m_value_6      = out_values_reg[6];
    assign m_value_7      = out_values_reg[7];
    assign m_frame_number = out_frame_reg;
    assign m_fields_found = out_found_reg;

    // A new result beat never overwrites one that has not been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && m_valid_reg) |-> m_ready)
        else $error("result beat overwritten before it was taken");

    // The stored byte count never passes the frame capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stored_count_reg <= CAP)
        else $error("stored byte count beyond capacity");

    // The magnitude stays within its cap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        num_reg.accum <= MAG_CAP)
        else $error("accumulator beyond magnitude cap");

    // A result beat reports between one and the configured number of fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_found_reg != 4'd0 && out_found_reg <= 4'(FIELD_COUNT)))
        else $error("field count out of range");

endmodule

// ----- tb/sv/afip_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII frame integer parser result checker
// Watches both channels of the parser core. Every accepted input beat runs
// through a cycle-free model of the frame parser; each closing 'E' queues
// the frame result it should produce. Accepted result beats are compared
// field by field with the oldest queued frame result.
// ----------------------------------------------------------------------------
module afip_result_checker import afip_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               s_buffer_start,

    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_value_0,
    input  logic signed [31:0] m_value_1,
    input  logic signed [31:0] m_value_2,
    input  logic signed [31:0] m_value_3,
    input  logic signed [31:0] m_value_4,
    input  logic signed [31:0] m_value_5,
    input  logic signed [31:0] m_value_6,
    input  logic signed [31:0] m_value_7,
    input  logic [15:0]        m_frame_number,
    input  logic [3:0]         m_fields_found,

    output int                 fail_count,
    output int                 pending,
    output int                 frames_checked
);

    typedef struct packed {
        logic [OUT_VALUES-1:0][31:0] values;
        logic [15:0]                 frame_number;
        logic [3:0]                  fields_found;
    } frame_result_t;

    // Frame results still owed by the block, oldest first.
    frame_result_t frame_result_q[$];

    // Parser model state.
    int          open_len;       // 0 when no frame is open, else 1 + bytes stored
    logic [2:0]  field_idx;
    num_state_t  num;
    logic        content_done;   // a zero byte was seen
    logic [31:0] field_vals [OUT_VALUES];
    logic [15:0] frame_cnt;

    int errs    = 0;
    int checked = 0;

    // Signed value of the number parsed so far, clamped to the 32-bit range.
    function automatic logic [31:0] settled_value(input num_state_t n);
        if (n.negative) begin
            return 32'd0 - n.accum;
        end
        return (n.accum > POS_MAX) ? POS_MAX : n.accum;
    endfunction

    task automatic clear_number();
        num.phase    = PH_SKIP;
        num.negative = 1'b0;
        num.accum    = 32'd0;
    endtask

    task automatic clear_frame();
        open_len     = 0;
        field_idx    = 3'd0;
        content_done = 1'b0;
        foreach (field_vals[k]) begin
            field_vals[k] = 32'd0;
        end
        clear_number();
    endtask

    // One stored content byte, before any zero byte.
    task automatic take_content(input logic [7:0] c);
        logic [63:0] grown;
        if (c == CHAR_NUL) begin
            content_done = 1'b1;
        end else if (c == CHAR_SEP) begin
            // The last field swallows further separators.
            if (int'(field_idx) + 1 < FIELD_COUNT_DEF) begin
                field_vals[field_idx] = settled_value(num);
                field_idx++;
                clear_number();
            end else begin
                num.phase = PH_DONE;
            end
        end else if (num.phase != PH_DONE) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                grown = 64'(num.accum) * 64'd10 + 64'(c - CHAR_ZERO);
                num.accum = (grown > 64'(MAG_CAP)) ? MAG_CAP : grown[31:0];
                num.phase = PH_DIGITS;
            end else if (num.phase == PH_SKIP &&
                         (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) begin
                // Leading whitespace is skipped.
            end else if (num.phase == PH_SKIP && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
                num.negative = (c == CHAR_MINUS);
                num.phase    = PH_SIGN;
            end else begin
                num.phase = PH_DONE;
            end
        end
    endtask

    // Advance the model by one accepted input beat.
    task automatic parse_byte(input logic [7:0] c, input logic buf_start);
        frame_result_t r;
        if (buf_start) begin
            clear_frame();
            frame_cnt = 16'd0;
        end
        if (c == CHAR_START) begin
            clear_frame();
            open_len = 1;
        end else if (open_len != 0) begin
            if (c == CHAR_END) begin
                field_vals[field_idx] = settled_value(num);
                for (int k = 0; k < OUT_VALUES; k++) begin
                    r.values[k] = field_vals[k];
                end
                r.frame_number = frame_cnt;
                r.fields_found = 4'(field_idx) + 4'd1;
                frame_result_q.push_back(r);
                frame_cnt++;
                clear_frame();
            end else if (open_len < FRAME_CAPACITY_DEF) begin
                // Bytes past the capacity are dropped.
                open_len++;
                if (!content_done) begin
                    take_content(c);
                end
            end
        end
    endtask

    // Compare one accepted result beat with the oldest expectation.
    task automatic check_result();
        logic [OUT_VALUES-1:0][31:0] got;
        frame_result_t                want;
        got = {m_value_7, m_value_6, m_value_5, m_value_4,
               m_value_3, m_value_2, m_value_1, m_value_0};
        if (frame_result_q.size() == 0) begin
            $error("unexpected result beat: frame_number %0d, fields_found %0d",
                   m_frame_number, m_fields_found);
            errs++;
        end else begin
            want = frame_result_q.pop_front();
            checked++;
            for (int k = 0; k < OUT_VALUES; k++) begin
                if (got[k] !== want.values[k]) begin
                    $error("value_%0d: expected %0d, actual %0d",
                           k, $signed(want.values[k]), $signed(got[k]));
                    errs++;
                end
            end
            if (m_frame_number !== want.frame_number) begin
                $error("frame_number: expected %0d, actual %0d",
                       want.frame_number, m_frame_number);
                errs++;
            end
            if (m_fields_found !== want.fields_found) begin
                $error("fields_found: expected %0d, actual %0d",
                       want.fields_found, m_fields_found);
                errs++;
            end
        end
    endtask

    // Sample both channels at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_frame();
            frame_cnt = 16'd0;
            frame_result_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte, s_buffer_start);
            end
            if (m_valid && m_ready) begin
                check_result();
            end
        end
        fail_count     <= errs;
        pending        <= frame_result_q.size();
        frames_checked <= checked;
    end

endmodule

// ----- tb/sv/tb_ascii_frame_integer_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the ASCII frame integer parser core
// Feeds a short directed byte sequence, then random frames with random
// whitespace, signs, digit runs near the saturation points, zero bytes,
// restarts, overlong frames and noise, with random gaps on the input and
// random back-pressure on the result channel. A separate checker does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_ascii_frame_integer_parser_core;
    import afip_pkg::*;

    localparam int         BYTE_TARGET = 1650;
    localparam logic [7:0] CHAR_JUNK   = 8'h78;  // 'x', no meaning to the parser

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic [7:0]         s_rx_byte      = 8'h00;
    logic               s_buffer_start = 1'b0;
    logic               m_ready        = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic signed [31:0] m_value_0, m_value_1, m_value_2, m_value_3;
    logic signed [31:0] m_value_4, m_value_5, m_value_6, m_value_7;
    logic [15:0]        m_frame_number;
    logic [3:0]         m_fields_found;

    int fail_count;
    int pending;
    int frames_checked;

    // No idling on either side while this is set.
    bit steady = 1'b0;

    int         bytes_total   = 0;
    int         bytes_counted = 0;
    logic [7:0] frame_q[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    ascii_frame_integer_parser_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_buffer_start (s_buffer_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value_0      (m_value_0),
        .m_value_1      (m_value_1),
        .m_value_2      (m_value_2),
        .m_value_3      (m_value_3),
        .m_value_4      (m_value_4),
        .m_value_5      (m_value_5),
        .m_value_6      (m_value_6),
        .m_value_7      (m_value_7),
        .m_frame_number (m_frame_number),
        .m_fields_found (m_fields_found)
    );

    afip_result_checker result_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_buffer_start (s_buffer_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value_0      (m_value_0),
        .m_value_1      (m_value_1),
        .m_value_2      (m_value_2),
        .m_value_3      (m_value_3),
        .m_value_4      (m_value_4),
        .m_value_5      (m_value_5),
        .m_value_6      (m_value_6),
        .m_value_7      (m_value_7),
        .m_frame_number (m_frame_number),
        .m_fields_found (m_fields_found),
        .fail_count     (fail_count),
        .pending        (pending),
        .frames_checked (frames_checked)
    );

    // Random back-pressure on the result channel.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 16);
        end
    end

    // Present one input beat and hold it until accepted. Each idle cycle
    // lowers valid in its own time step, so valid is never lowered and
    // raised in the same step.
    task automatic send_beat(input logic [7:0] b, input logic buf_start);
        while (!steady && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_rx_byte      <= b;
        s_buffer_start <= buf_start;
        do @(posedge aclk); while (!s_ready);
        bytes_total++;
    endtask

    task automatic send_digits(input string t);
        foreach (t[i]) begin
            send_beat(t[i], 1'b0);
        end
    endtask

    // Hold the input until every owed frame result has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Append one random field, with its leading separator unless first.
    task automatic add_field(input bit first);
        longint unsigned mag;
        string           digits;
        int              kind;
        logic [7:0]      junk;
        if (!first) begin
            frame_q.push_back(CHAR_SEP);
        end
        repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0) begin
            frame_q.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB + 8'($urandom_range(4)));
        end
        case ($urandom_range(5))
            0: begin
                frame_q.push_back(CHAR_PLUS);
            end
            1, 2: begin
                frame_q.push_back(CHAR_MINUS);
            end
            default: begin
            end
        endcase
        // A second sign ends the number at once.
        if ($urandom_range(15) == 0) begin
            frame_q.push_back(CHAR_MINUS);
        end
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2, 3, 4: mag = $urandom_range(99);
            5, 6:          mag = $urandom_range(99999);
            7:             mag = 64'd2147483640 + $urandom_range(15);
            default:       mag = longint'($urandom) * 10 + $urandom_range(9);
        endcase
        // Kind nine leaves the field without digits.
        if (kind != 9) begin
            if ($urandom_range(7) == 0) begin
                repeat ($urandom_range(1, 3)) frame_q.push_back(CHAR_ZERO);
            end
            digits = $sformatf("%0d", mag);
            foreach (digits[i]) begin
                frame_q.push_back(digits[i]);
            end
        end
        // Trailing junk, including a sign after the digits.
        if ($urandom_range(9) == 0) begin
            junk = 8'($urandom_range(33, 126));
            if (junk == CHAR_START || junk == CHAR_END) begin
                junk = CHAR_MINUS;
            end
            frame_q.push_back(junk);
        end
    endtask

    // One well-formed frame: up to nine fields, sometimes a zero byte or a
    // restart inside, closed by 'E'.
    task automatic send_frame();
        frame_q.delete();
        for (int f = $urandom_range(1, 9) - 1; f >= 0; f--) begin
            add_field(frame_q.size() == 0);
        end
        if ($urandom_range(19) == 0) begin
            frame_q.insert($urandom_range(frame_q.size()), CHAR_NUL);
        end
        if ($urandom_range(29) == 0) begin
            frame_q.insert($urandom_range(frame_q.size()), CHAR_START);
        end
        send_beat(CHAR_START, $urandom_range(19) == 0);
        foreach (frame_q[i]) begin
            send_beat(frame_q[i], 1'b0);
        end
        send_beat(CHAR_END, 1'b0);
        bytes_counted += frame_q.size() + 2;
    endtask

    // Random bytes across the full range, with random buffer starts.
    task automatic send_noise();
        repeat ($urandom_range(1, 6)) begin
            send_beat(8'($urandom), $urandom_range(9) == 0);
        end
    endtask

    // A frame left open; the next 'S' or buffer start abandons it.
    task automatic send_broken();
        frame_q.delete();
        add_field(1'b1);
        send_beat(CHAR_START, 1'b0);
        foreach (frame_q[i]) begin
            send_beat(frame_q[i], 1'b0);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int frame_idx;
        int pick;
        int guard;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: a byte outside any frame, a restart, sign handling,
        // whitespace, a zero byte, an empty frame, the top byte value and a
        // buffer start that closes an open frame.
        send_beat(CHAR_JUNK, 1'b1);
        send_beat(CHAR_START, 1'b0);
        send_digits("12");
        send_beat(CHAR_START, 1'b0);
        send_beat(CHAR_PLUS, 1'b0);
        send_digits("7");
        send_beat(CHAR_SEP, 1'b0);
        send_beat(CHAR_MINUS, 1'b0);
        send_beat(CHAR_MINUS, 1'b0);
        send_digits("3");
        send_beat(CHAR_SEP, 1'b0);
        send_digits("4");
        send_beat(CHAR_MINUS, 1'b0);
        send_beat(CHAR_SEP, 1'b0);
        send_beat(CHAR_SPACE, 1'b0);
        send_beat(CHAR_TAB, 1'b0);
        send_digits("8");
        send_beat(CHAR_NUL, 1'b0);
        send_digits("9");
        send_beat(CHAR_END, 1'b0);
        send_beat(CHAR_START, 1'b0);
        send_beat(CHAR_END, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(CHAR_START, 1'b0);
        send_digits("5");
        send_beat(CHAR_END, 1'b1);
        drain_results();

        // Random frames, mostly well formed.
        frame_idx = 0;
        while (bytes_counted < BYTE_TARGET) begin
            steady <= (frame_idx >= 40 && frame_idx < 75);
            if (frame_idx % 60 == 59) begin
                drain_results();
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_noise();
            end else if (pick < 13) begin
                send_broken();
            end else begin
                send_frame();
            end
            frame_idx++;
        end
        s_valid <= 1'b0;

        // Let the last results out, then allow for the pipeline latency.
        guard = 0;
        do begin
            @(posedge aclk);
            guard++;
        end while (pending != 0 && guard < 20000);
        repeat (8) @(posedge aclk);
        if (pending != 0) begin
            $error("%0d frame results never arrived", pending);
        end

        $display("Sent %0d bytes (%0d in well-formed frames) and checked %0d frame results.",
                 bytes_total, bytes_counted, frames_checked);
        $display("Covered restarts, buffer starts, zero bytes, saturation, dropped bytes, stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
